// ===== hdl/radix_integer_text_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radix integer text parser.
// Concurrent assertions are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define RITP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define RITP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RITP_ASSERT(lbl, clk, rst, prop, msg)

`define RITP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/ritp_pkg.sv =====
// ----------------------------------------------------------------------------
// ritp_pkg
// Types, constants and the character decoder shared by the text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ritp_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned RadixWidth = 6;
  localparam int unsigned DigitWidth = 8;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth = RadixWidth;
  localparam int unsigned ProductWidth = ValueWidth + RadixWidth;

  localparam logic [CfgIndexWidth-1:0] CfgRadix = 1'b0;
  localparam logic [CfgIndexWidth-1:0] CfgSignedMode = 1'b1;

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
  localparam logic [DigitWidth-1:0] NoDigit = 8'd255;
  localparam logic [7:0] MinusSign = 8'h2d;
  localparam logic [ValueWidth-1:0] SignBit = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] number_value;
    logic                  parse_error;
    logic                  stopped_on_byte;
  } out_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] accumulator;
    logic                  seen_digit;
    logic                  overflowed;
    logic                  is_negative;
    logic                  at_number_start;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    accumulator:     '0,
    seen_digit:      1'b0,
    overflowed:      1'b0,
    is_negative:     1'b0,
    at_number_start: 1'b1
  };

  function automatic logic [DigitWidth-1:0] digit_of(input logic [7:0] b);
    logic [DigitWidth-1:0] d;
    begin
      if (b >= 8'h30 && b <= 8'h39) begin
        d = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h5a) begin
        d = b - 8'h41 + 8'd10;
      end else if (b >= 8'h61 && b <= 8'h7a) begin
        d = b - 8'h61 + 8'd10;
      end else begin
        d = NoDigit;
      end
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/radix_integer_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// radix_integer_text_parser_core
// Result path: input register holds the ending byte; output register holds its result.
// Throughput: one byte per cycle (multiply-add loop) unless a result meets full output.
// Reset: synchronous; radix returns to 10, signed mode off, state cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_integer_text_parser_core_macros.svh"

module radix_integer_text_parser_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ritp_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ritp_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [ritp_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [ritp_pkg::CfgDataWidth-1:0]      cfg_data
);
  import ritp_pkg::*;

  logic [RadixWidth-1:0] radix;
  logic                  signed_mode;
  logic                  in_full;
  in_item_t              in_item;
  parse_state_t          state;
  parse_state_t          state_next;
  logic                  has_result;
  out_item_t             result;
  logic                  can_load;
  logic                  fire;

  assign fire     = in_full && (!has_result || can_load);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RadixReset;
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgRadix:      radix <= cfg_data[RadixWidth-1:0];
        CfgSignedMode: signed_mode <= cfg_data[0];
        default:       radix <= radix;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (fire) begin
      state <= state_next;
    end
  end

  ritp_step u_step (
    .state_q     (state),
    .item        (in_item),
    .radix       (radix),
    .signed_mode (signed_mode),
    .state_next  (state_next),
    .has_result  (has_result),
    .result      (result)
  );

  ritp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && has_result),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RITP_ASSERT(a_start_after_result, clk, rst, (fire && has_result) |=> state.at_number_start, "Parser state not cleared after a result.")
  `RITP_ASSERT(a_no_digit_zero_acc, clk, rst, !state.seen_digit |-> (state.accumulator == '0), "Accumulator nonzero before any digit.")
  `RITP_ASSERT(a_overflow_needs_digit, clk, rst, state.overflowed |-> state.seen_digit, "Overflow flagged without a digit.")
  `RITP_ASSERT(a_unsigned_error_zero, clk, rst, (out_valid && out_data.parse_error && !signed_mode) |-> (out_data.number_value == '0), "Unsigned error result is not zero.")
  `RITP_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && !in_full), "Reset did not empty the pipeline.")

endmodule

`default_nettype wire

// ===== hdl/ritp_step.sv =====
// ----------------------------------------------------------------------------
// ritp_step
// Next-state and result logic for one character: digit decode, one
// multiply-add by the radix with an exact overflow check, and the finish.
// ----------------------------------------------------------------------------
`default_nettype none

module ritp_step (
  input  ritp_pkg::parse_state_t                state_q,
  input  ritp_pkg::in_item_t                    item,
  input  logic [ritp_pkg::RadixWidth-1:0]       radix,
  input  logic                                  signed_mode,
  output ritp_pkg::parse_state_t                state_next,
  output logic                                  has_result,
  output ritp_pkg::out_item_t                   result
);
  import ritp_pkg::*;

  logic [DigitWidth-1:0]   digit;
  logic [ProductWidth-1:0] product;
  logic [ProductWidth-1:0] sum;
  logic                    is_minus;
  logic                    ends_number;
  logic                    fin_error;
  logic [ValueWidth-1:0]   fin_mag;
  logic [ValueWidth-1:0]   fin_value;

  assign digit   = digit_of(item.text_byte);
  assign product = {{RadixWidth{1'b0}}, state_q.accumulator} *
                   {{ValueWidth{1'b0}}, radix};
  assign sum     = product + {{(ProductWidth-DigitWidth){1'b0}}, digit};
  assign is_minus = signed_mode && state_q.at_number_start && (item.text_byte == MinusSign);
  assign ends_number = (digit >= {{(DigitWidth-RadixWidth){1'b0}}, radix});

  always_comb begin
    fin_error = !state_q.seen_digit || state_q.overflowed;
    fin_mag   = fin_error ? '0 : state_q.accumulator;
    fin_value = fin_mag;
    if (signed_mode) begin
      if (state_q.is_negative) begin
        fin_value = '0 - fin_mag;
        if (fin_mag > SignBit) begin
          fin_error = 1'b1;
        end
      end else if (fin_mag[ValueWidth-1]) begin
        fin_error = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state_q;
    has_result = 1'b0;
    result.number_value    = fin_value;
    result.parse_error     = fin_error;
    result.stopped_on_byte = !item.end_of_input;
    if (item.end_of_input) begin
      has_result = 1'b1;
      state_next = StateReset;
    end else if (is_minus) begin
      state_next.is_negative     = 1'b1;
      state_next.at_number_start = 1'b0;
    end else if (ends_number) begin
      has_result = 1'b1;
      state_next = StateReset;
    end else begin
      state_next.accumulator     = sum[ValueWidth-1:0];
      state_next.overflowed      = state_q.overflowed || (|sum[ProductWidth-1:ValueWidth]);
      state_next.seen_digit      = 1'b1;
      state_next.at_number_start = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ritp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ritp_out_stage
// Result register toward the output channel; it can take a new result in the
// same cycle in which the held one transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module ritp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  ritp_pkg::out_item_t load_data,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output ritp_pkg::out_item_t out_data
);
  import ritp_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire
